// File: hw/rtl/igs_pkg.sv
// Shared types and constants for the gravity step block
package igs_pkg;

    localparam int AW = 128;
    localparam int QW = 88;
    localparam int MW = 63;
    localparam int CNTW = 7;

    localparam logic [CNTW-1:0] CNT_GM = 7'd31;
    localparam logic [CNTW-1:0] CNT_MUL = 7'd62;
    localparam logic [CNTW-1:0] CNT_SQRT = 7'd63;
    localparam logic [CNTW-1:0] CNT_DIV1 = 7'd87;
    localparam logic [CNTW-1:0] CNT_DIV = 7'd63;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam logic [2:0] CFG_GRAV = 3'd0;
    localparam logic [2:0] CFG_POS_X = 3'd1;
    localparam logic [2:0] CFG_POS_Y = 3'd2;
    localparam logic [2:0] CFG_VEL_X = 3'd3;
    localparam logic [2:0] CFG_VEL_Y = 3'd4;

    typedef struct packed {
        logic done;
        logic zero;
        logic gsat;
    } core_stat_t;

endpackage

// File: hw/rtl/igs_addsub.sv
// Shared wide add/subtract unit with carry out
module igs_addsub
(
    input  logic [igs_pkg::AW-1:0] a,
    input  logic [igs_pkg::AW-1:0] b,
    input  logic                   sub,
    output logic [igs_pkg::AW-1:0] sum,
    output logic                   cout
);

    logic [igs_pkg::AW:0] full;

    assign full = {1'b0, a} + {1'b0, b ^ {igs_pkg::AW{sub}}} + (igs_pkg::AW+1)'(sub);
    assign sum = full[igs_pkg::AW-1:0];
    assign cout = full[igs_pkg::AW];

endmodule

// File: hw/rtl/igs_core.sv
// Sequencer computing the acceleration with one shared add/subtract unit
module igs_core
#(
    parameter int VEL_WIDTH = 40
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [igs_pkg::MW-1:0]      mx,
    input  logic [igs_pkg::MW-1:0]      my,
    input  logic                        nx,
    input  logic                        ny,
    input  logic [31:0]                 grav,
    input  logic [31:0]                 mass,
    output logic signed [VEL_WIDTH-1:0] ax,
    output logic signed [VEL_WIDTH-1:0] ay,
    output igs_pkg::core_stat_t         stat
);

    localparam int AW = igs_pkg::AW;
    localparam int QW = igs_pkg::QW;

    localparam logic [4:0] C_IDLE = 5'd0;
    localparam logic [4:0] C_GM = 5'd1;
    localparam logic [4:0] C_LSQX = 5'd2;
    localparam logic [4:0] C_SQX = 5'd3;
    localparam logic [4:0] C_LSQY = 5'd4;
    localparam logic [4:0] C_SQY = 5'd5;
    localparam logic [4:0] C_LSQRT = 5'd6;
    localparam logic [4:0] C_SQRT = 5'd7;
    localparam logic [4:0] C_LDIV1 = 5'd8;
    localparam logic [4:0] C_DIV1 = 5'd9;
    localparam logic [4:0] C_LMULX = 5'd10;
    localparam logic [4:0] C_MULX = 5'd11;
    localparam logic [4:0] C_LDIVX = 5'd12;
    localparam logic [4:0] C_DIVX = 5'd13;
    localparam logic [4:0] C_LMULY = 5'd14;
    localparam logic [4:0] C_MULY = 5'd15;
    localparam logic [4:0] C_LDIVY = 5'd16;
    localparam logic [4:0] C_DIVY = 5'd17;
    localparam logic [4:0] C_LFIN = 5'd18;
    localparam logic [4:0] C_FIN = 5'd19;

    logic [4:0]                  phase_reg;
    logic [igs_pkg::CNTW-1:0]    cnt_reg;
    logic [AW-1:0]               acc_reg;
    logic [AW-1:0]               sh_reg;
    logic [AW-1:0]               r2_reg;
    logic [QW-1:0]               mbit_reg;
    logic [63:0]                 root_reg;
    logic [63:0]                 gm_reg;
    logic [igs_pkg::MW-1:0]      mx_reg;
    logic [igs_pkg::MW-1:0]      my_reg;
    logic                        nx_reg;
    logic                        ny_reg;
    logic                        zero_reg;
    logic                        gsat_reg;
    logic signed [VEL_WIDTH-1:0] ax_reg;
    logic signed [VEL_WIDTH-1:0] ay_reg;

    logic [AW-1:0]              au_a;
    logic [AW-1:0]              au_b;
    logic                       au_sub;
    logic [AW-1:0]              au_sum;
    logic                       au_cout;
    logic                       gover;
    logic [VEL_WIDTH-2:0]       g_sat;
    logic [VEL_WIDTH-1:0]       qv;
    logic                       last;

    igs_addsub u_addsub
    (
        .a    (au_a),
        .b    (au_b),
        .sub  (au_sub),
        .sum  (au_sum),
        .cout (au_cout)
    );

    always_comb
    begin
        au_a = acc_reg;
        au_b = sh_reg;
        au_sub = 1'b0;
        unique case (phase_reg)
            C_SQRT:
            begin
                au_a = {acc_reg[AW-3:0], sh_reg[AW-1:AW-2]};
                au_b = AW'({root_reg, 2'b01});
                au_sub = 1'b1;
            end
            C_DIV1:
            begin
                au_a = {acc_reg[AW-2:0], sh_reg[AW-1]};
                au_b = r2_reg;
                au_sub = 1'b1;
            end
            C_DIVX, C_DIVY:
            begin
                au_a = {acc_reg[AW-2:0], sh_reg[AW-1]};
                au_b = AW'(root_reg);
                au_sub = 1'b1;
            end
            default:
            begin
                au_a = acc_reg;
                au_b = sh_reg;
                au_sub = 1'b0;
            end
        endcase
    end

    assign gover = |mbit_reg[QW-1:VEL_WIDTH-1];
    assign g_sat = gover ? {(VEL_WIDTH-1){1'b1}} : mbit_reg[VEL_WIDTH-2:0];
    assign qv = mbit_reg[VEL_WIDTH-1:0];
    assign last = (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= C_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (phase_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= (mx == '0 && my == '0) ? C_FIN : C_GM;
                        cnt_reg <= igs_pkg::CNT_GM;
                    end
                end
                C_LSQX:
                begin
                    phase_reg <= C_SQX;
                    cnt_reg <= igs_pkg::CNT_MUL;
                end
                C_LSQY:
                begin
                    phase_reg <= C_SQY;
                    cnt_reg <= igs_pkg::CNT_MUL;
                end
                C_LSQRT:
                begin
                    phase_reg <= C_SQRT;
                    cnt_reg <= igs_pkg::CNT_SQRT;
                end
                C_LDIV1:
                begin
                    phase_reg <= C_DIV1;
                    cnt_reg <= igs_pkg::CNT_DIV1;
                end
                C_LMULX:
                begin
                    phase_reg <= C_MULX;
                    cnt_reg <= igs_pkg::CNT_MUL;
                end
                C_LDIVX:
                begin
                    phase_reg <= C_DIVX;
                    cnt_reg <= igs_pkg::CNT_DIV;
                end
                C_LMULY:
                begin
                    phase_reg <= C_MULY;
                    cnt_reg <= igs_pkg::CNT_MUL;
                end
                C_LDIVY:
                begin
                    phase_reg <= C_DIVY;
                    cnt_reg <= igs_pkg::CNT_DIV;
                end
                C_LFIN:
                begin
                    phase_reg <= C_FIN;
                end
                C_FIN:
                begin
                    phase_reg <= C_IDLE;
                end
                default:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last)
                    begin
                        phase_reg <= phase_reg + 5'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    mx_reg <= mx;
                    my_reg <= my;
                    nx_reg <= nx;
                    ny_reg <= ny;
                    zero_reg <= (mx == '0 && my == '0);
                    gsat_reg <= 1'b0;
                    acc_reg <= '0;
                    sh_reg <= AW'(grav);
                    mbit_reg <= QW'(mass);
                    ax_reg <= '0;
                    ay_reg <= '0;
                end
            end
            C_GM, C_SQX, C_SQY, C_MULX, C_MULY:
            begin
                if (mbit_reg[0])
                begin
                    acc_reg <= au_sum;
                end
                sh_reg <= sh_reg << 1;
                mbit_reg <= mbit_reg >> 1;
            end
            C_LSQX:
            begin
                gm_reg <= acc_reg[63:0];
                acc_reg <= '0;
                sh_reg <= AW'(mx_reg);
                mbit_reg <= QW'(mx_reg);
            end
            C_LSQY:
            begin
                sh_reg <= AW'(my_reg);
                mbit_reg <= QW'(my_reg);
            end
            C_LSQRT:
            begin
                r2_reg <= acc_reg;
                sh_reg <= acc_reg;
                acc_reg <= '0;
                root_reg <= '0;
            end
            C_SQRT:
            begin
                acc_reg <= au_cout ? au_sum : au_a;
                root_reg <= {root_reg[62:0], au_cout};
                sh_reg <= sh_reg << 2;
            end
            C_LDIV1:
            begin
                acc_reg <= '0;
                sh_reg <= {gm_reg, 64'b0};
                mbit_reg <= '0;
            end
            C_DIV1, C_DIVX, C_DIVY:
            begin
                acc_reg <= au_cout ? au_sum : au_a;
                sh_reg <= sh_reg << 1;
                mbit_reg <= {mbit_reg[QW-2:0], au_cout};
            end
            C_LMULX:
            begin
                gsat_reg <= gover;
                acc_reg <= '0;
                sh_reg <= AW'(g_sat);
                mbit_reg <= QW'(mx_reg);
                gm_reg <= 64'(g_sat);
            end
            C_LDIVX, C_LDIVY:
            begin
                acc_reg <= AW'(acc_reg[AW-1:64]);
                sh_reg <= {acc_reg[63:0], 64'b0};
                mbit_reg <= '0;
            end
            C_LMULY:
            begin
                ax_reg <= nx_reg ? -qv : qv;
                acc_reg <= '0;
                sh_reg <= AW'(gm_reg);
                mbit_reg <= QW'(my_reg);
            end
            C_LFIN:
            begin
                ay_reg <= ny_reg ? -qv : qv;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign ax = ax_reg;
    assign ay = ay_reg;
    assign stat.done = (phase_reg == C_FIN);
    assign stat.zero = zero_reg;
    assign stat.gsat = gsat_reg;

endmodule

// File: hw/rtl/inverse_square_gravity_step.sv
// Top level: handshake, configuration, body state and saturating updates
// A request is taken only in the idle state, so a new one waits until the last result has
// been handed to the output register, longer while a result waits on out_stall; the
// bit-serial multiply, square root and divide passes through the shared 128-bit
// add/subtract unit set the processing time, and are skipped when the distance is zero.
// Reset: asynchronous active low; clears body state to zero, G to 1.0.
module inverse_square_gravity_step
#(
    parameter int POS_WIDTH = 48,
    parameter int VEL_WIDTH = 40,
    localparam int CW = (POS_WIDTH > VEL_WIDTH) ?
                        ((POS_WIDTH > 32) ? POS_WIDTH : 32) :
                        ((VEL_WIDTH > 32) ? VEL_WIDTH : 32)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [CW-1:0]               cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [POS_WIDTH-1:0] parent_pos_x,
    input  logic signed [POS_WIDTH-1:0] parent_pos_y,
    input  logic [31:0]                 parent_mass,
    input  logic signed [VEL_WIDTH-1:0] frame_vel_x,
    input  logic signed [VEL_WIDTH-1:0] frame_vel_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [POS_WIDTH-1:0] new_pos_x,
    output logic signed [POS_WIDTH-1:0] new_pos_y,
    output logic signed [VEL_WIDTH-1:0] new_vel_x,
    output logic signed [VEL_WIDTH-1:0] new_vel_y,
    output logic signed [VEL_WIDTH-1:0] accel_x,
    output logic signed [VEL_WIDTH-1:0] accel_y,
    output logic signed [VEL_WIDTH-1:0] total_vel_x,
    output logic signed [VEL_WIDTH-1:0] total_vel_y,
    output logic [1:0]                  status
);

    localparam int P = POS_WIDTH;
    localparam int V = VEL_WIDTH;
    localparam int SW = ((P > V) ? P : V) + 1;
    localparam int MW = igs_pkg::MW;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_DIFF = 3'd1;
    localparam logic [2:0] T_CORE = 3'd2;
    localparam logic [2:0] T_VEL = 3'd3;
    localparam logic [2:0] T_TOT = 3'd4;
    localparam logic [2:0] T_POS = 3'd5;

    localparam logic signed [V-1:0] VMAX = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0] VMIN = {1'b1, {(V-1){1'b0}}};
    localparam logic signed [SW-1:0] PMAX = SW'($signed({1'b0, {(P-1){1'b1}}}));
    localparam logic signed [SW-1:0] PMIN = SW'($signed({1'b1, {(P-1){1'b0}}}));

    logic [2:0]          state_reg;
    logic [31:0]         grav_reg;
    logic signed [P-1:0] pos_x_reg;
    logic signed [P-1:0] pos_y_reg;
    logic signed [V-1:0] vel_x_reg;
    logic signed [V-1:0] vel_y_reg;
    logic signed [P-1:0] pp_x_reg;
    logic signed [P-1:0] pp_y_reg;
    logic [31:0]         mass_reg;
    logic signed [V-1:0] fv_x_reg;
    logic signed [V-1:0] fv_y_reg;
    logic signed [V-1:0] ax_reg;
    logic signed [V-1:0] ay_reg;
    logic signed [V-1:0] tot_x_reg;
    logic signed [V-1:0] tot_y_reg;
    logic                zero_reg;
    logic                sat_reg;
    logic                out_valid_reg;
    logic signed [P-1:0] o_pos_x_reg;
    logic signed [P-1:0] o_pos_y_reg;
    logic signed [V-1:0] o_vel_x_reg;
    logic signed [V-1:0] o_vel_y_reg;
    logic signed [V-1:0] o_ax_reg;
    logic signed [V-1:0] o_ay_reg;
    logic signed [V-1:0] o_tot_x_reg;
    logic signed [V-1:0] o_tot_y_reg;
    logic [1:0]          o_status_reg;

    logic signed [P:0]   dx;
    logic signed [P:0]   dy;
    logic [P:0]          magx;
    logic [P:0]          magy;
    logic [64:0]         magx_w;
    logic [64:0]         magy_w;
    logic                clamp_x;
    logic                clamp_y;
    logic [MW-1:0]       mx;
    logic [MW-1:0]       my;
    logic                start;
    logic signed [V-1:0] core_ax;
    logic signed [V-1:0] core_ay;
    igs_pkg::core_stat_t cst;

    logic signed [V:0]    vs_x;
    logic signed [V:0]    vs_y;
    logic signed [V:0]    ts_x;
    logic signed [V:0]    ts_y;
    logic signed [SW-1:0] ps_x;
    logic signed [SW-1:0] ps_y;
    logic signed [V-1:0]  vn_x;
    logic signed [V-1:0]  vn_y;
    logic signed [V-1:0]  tn_x;
    logic signed [V-1:0]  tn_y;
    logic signed [P-1:0]  pn_x;
    logic signed [P-1:0]  pn_y;
    logic                 v_ovf;
    logic                 t_ovf;
    logic                 p_ovf;
    logic                 out_busy;

    assign dx = {pp_x_reg[P-1], pp_x_reg} - {pos_x_reg[P-1], pos_x_reg};
    assign dy = {pp_y_reg[P-1], pp_y_reg} - {pos_y_reg[P-1], pos_y_reg};
    assign magx = dx[P] ? $unsigned(-dx) : $unsigned(dx);
    assign magy = dy[P] ? $unsigned(-dy) : $unsigned(dy);
    assign magx_w = 65'(magx);
    assign magy_w = 65'(magy);
    assign clamp_x = |magx_w[64:63];
    assign clamp_y = |magy_w[64:63];
    assign mx = clamp_x ? {MW{1'b1}} : magx_w[MW-1:0];
    assign my = clamp_y ? {MW{1'b1}} : magy_w[MW-1:0];
    assign start = (state_reg == T_DIFF);

    igs_core #(.VEL_WIDTH(V)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mx    (mx),
        .my    (my),
        .nx    (dx[P]),
        .ny    (dy[P]),
        .grav  (grav_reg),
        .mass  (mass_reg),
        .ax    (core_ax),
        .ay    (core_ay),
        .stat  (cst)
    );

    always_comb
    begin
        vs_x = {vel_x_reg[V-1], vel_x_reg} + {ax_reg[V-1], ax_reg};
        vs_y = {vel_y_reg[V-1], vel_y_reg} + {ay_reg[V-1], ay_reg};
        vn_x = (vs_x[V] != vs_x[V-1]) ? (vs_x[V] ? VMIN : VMAX) : vs_x[V-1:0];
        vn_y = (vs_y[V] != vs_y[V-1]) ? (vs_y[V] ? VMIN : VMAX) : vs_y[V-1:0];
        v_ovf = (vs_x[V] != vs_x[V-1]) || (vs_y[V] != vs_y[V-1]);

        ts_x = {fv_x_reg[V-1], fv_x_reg} + {vel_x_reg[V-1], vel_x_reg};
        ts_y = {fv_y_reg[V-1], fv_y_reg} + {vel_y_reg[V-1], vel_y_reg};
        tn_x = (ts_x[V] != ts_x[V-1]) ? (ts_x[V] ? VMIN : VMAX) : ts_x[V-1:0];
        tn_y = (ts_y[V] != ts_y[V-1]) ? (ts_y[V] ? VMIN : VMAX) : ts_y[V-1:0];
        t_ovf = (ts_x[V] != ts_x[V-1]) || (ts_y[V] != ts_y[V-1]);

        ps_x = SW'(pos_x_reg) + SW'(tot_x_reg >>> 8);
        ps_y = SW'(pos_y_reg) + SW'(tot_y_reg >>> 8);
        pn_x = (ps_x > PMAX) ? PMAX[P-1:0] : ((ps_x < PMIN) ? PMIN[P-1:0] : ps_x[P-1:0]);
        pn_y = (ps_y > PMAX) ? PMAX[P-1:0] : ((ps_y < PMIN) ? PMIN[P-1:0] : ps_y[P-1:0]);
        p_ovf = (ps_x > PMAX) || (ps_x < PMIN) || (ps_y > PMAX) || (ps_y < PMIN);
    end

    assign out_busy = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            grav_reg <= 32'd16777216;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == T_POS && !out_busy)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE:
                begin
                    if (cfg_we)
                    begin
                        unique case (cfg_index)
                            igs_pkg::CFG_GRAV:  grav_reg <= cfg_data[31:0];
                            igs_pkg::CFG_POS_X: pos_x_reg <= cfg_data[P-1:0];
                            igs_pkg::CFG_POS_Y: pos_y_reg <= cfg_data[P-1:0];
                            igs_pkg::CFG_VEL_X: vel_x_reg <= cfg_data[V-1:0];
                            igs_pkg::CFG_VEL_Y: vel_y_reg <= cfg_data[V-1:0];
                            default:            grav_reg <= grav_reg;
                        endcase
                    end
                    if (in_valid)
                    begin
                        state_reg <= T_DIFF;
                    end
                end
                T_DIFF:
                begin
                    state_reg <= T_CORE;
                end
                T_CORE:
                begin
                    if (cst.done)
                    begin
                        state_reg <= T_VEL;
                    end
                end
                T_VEL:
                begin
                    vel_x_reg <= vn_x;
                    vel_y_reg <= vn_y;
                    state_reg <= T_TOT;
                end
                T_TOT:
                begin
                    state_reg <= T_POS;
                end
                T_POS:
                begin
                    if (!out_busy)
                    begin
                        pos_x_reg <= pn_x;
                        pos_y_reg <= pn_y;
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    pp_x_reg <= parent_pos_x;
                    pp_y_reg <= parent_pos_y;
                    mass_reg <= parent_mass;
                    fv_x_reg <= frame_vel_x;
                    fv_y_reg <= frame_vel_y;
                end
            end
            T_DIFF:
            begin
                sat_reg <= clamp_x || clamp_y;
            end
            T_CORE:
            begin
                if (cst.done)
                begin
                    ax_reg <= core_ax;
                    ay_reg <= core_ay;
                    zero_reg <= cst.zero;
                    sat_reg <= sat_reg || cst.gsat;
                end
            end
            T_VEL:
            begin
                sat_reg <= sat_reg || v_ovf;
            end
            T_TOT:
            begin
                tot_x_reg <= tn_x;
                tot_y_reg <= tn_y;
                sat_reg <= sat_reg || t_ovf;
            end
            T_POS:
            begin
                if (!out_busy)
                begin
                    o_pos_x_reg <= pn_x;
                    o_pos_y_reg <= pn_y;
                    o_vel_x_reg <= vel_x_reg;
                    o_vel_y_reg <= vel_y_reg;
                    o_ax_reg <= ax_reg;
                    o_ay_reg <= ay_reg;
                    o_tot_x_reg <= tot_x_reg;
                    o_tot_y_reg <= tot_y_reg;
                    o_status_reg <= zero_reg ? igs_pkg::ST_ZERO :
                                    ((sat_reg || p_ovf) ? igs_pkg::ST_SAT : igs_pkg::ST_OK);
                end
            end
            default:
            begin
                sat_reg <= sat_reg;
            end
        endcase
    end

    assign in_stall = (state_reg != T_IDLE);
    assign out_valid = out_valid_reg;
    assign new_pos_x = o_pos_x_reg;
    assign new_pos_y = o_pos_y_reg;
    assign new_vel_x = o_vel_x_reg;
    assign new_vel_y = o_vel_y_reg;
    assign accel_x = o_ax_reg;
    assign accel_y = o_ay_reg;
    assign total_vel_x = o_tot_x_reg;
    assign total_vel_y = o_tot_y_reg;
    assign status = o_status_reg;

`ifndef NO_ASSERTIONS
    a_done_in_core: assert property (@(posedge clk) disable iff (!rst_n)
        cst.done |-> state_reg == T_CORE)
        else $error("core finished outside of wait state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == T_DIFF)
        else $error("accepted request did not start");

    a_zero_no_accel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == igs_pkg::ST_ZERO) |-> (accel_x == '0 && accel_y == '0))
        else $error("zero distance with nonzero acceleration");
`endif

endmodule

// File: verif/testbench.sv
// Testbench for inverse_square_gravity_step: directed tables, then predictor-checked random phases
`timescale 1ns / 1ps

module testbench;

    localparam int PW = 48;
    localparam int VW = 40;
    localparam logic [2:0] CFG_UNUSED = 3'd5;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 210;

    typedef struct {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic [31:0] mass;
        logic signed [VW-1:0] fx;
        logic signed [VW-1:0] fy;
    } request_t;

    typedef struct {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic signed [VW-1:0] ax;
        logic signed [VW-1:0] ay;
        logic signed [VW-1:0] tx;
        logic signed [VW-1:0] ty;
        logic [1:0] st;
    } result_t;

    typedef struct {
        request_t req;
        bit typed;
        result_t res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [PW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [PW-1:0] parent_pos_x = '0;
    logic signed [PW-1:0] parent_pos_y = '0;
    logic [31:0] parent_mass = '0;
    logic signed [VW-1:0] frame_vel_x = '0;
    logic signed [VW-1:0] frame_vel_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [PW-1:0] new_pos_x;
    logic signed [PW-1:0] new_pos_y;
    logic signed [VW-1:0] new_vel_x;
    logic signed [VW-1:0] new_vel_y;
    logic signed [VW-1:0] accel_x;
    logic signed [VW-1:0] accel_y;
    logic signed [VW-1:0] total_vel_x;
    logic signed [VW-1:0] total_vel_y;
    logic [1:0] status;

    inverse_square_gravity_step uut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [31:0] grav_g = 32'd16777216;
    logic signed [PW-1:0] body_px = '0;
    logic signed [PW-1:0] body_py = '0;
    logic signed [VW-1:0] body_vx = '0;
    logic signed [VW-1:0] body_vy = '0;

    result_t expected_results[$];
    int errors = 0;
    bit idle_off = 0;
    bit hold_long = 0;

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int w, inout bit flag);
        logic signed [65:0] s;
        logic signed [65:0] hi;
        s = 66'(a) + 66'(b);
        hi = (66'sd1 <<< (w - 1)) - 1;
        if (s > hi)
        begin
            flag = 1;
            return hi[63:0];
        end
        if (s < -hi - 1)
        begin
            flag = 1;
            return 64'(-hi - 1);
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] dist_mag(input logic signed [PW-1:0] p,
                                             input logic signed [PW-1:0] b,
                                             output bit neg, inout bit flag);
        logic signed [64:0] d;
        logic [64:0] m;
        d = 65'(p);
        d = d - 65'(b);
        neg = d < 0;
        m = neg ? -d : d;
        if (m > 65'h7FFF_FFFF_FFFF_FFFF)
        begin
            flag = 1;
            m = 65'h7FFF_FFFF_FFFF_FFFF;
        end
        return m[63:0];
    endfunction

    function automatic result_t gravity_step(input request_t q);
        result_t r;
        bit sat, zero, nx, ny;
        logic [127:0] mx, my, r2, num, quo, root, cand, gv;
        logic signed [63:0] ax, ay, tx, ty, vx, vy, px, py;
        sat = 0;
        zero = 0;
        ax = 0;
        ay = 0;
        mx = 128'(dist_mag(q.px, body_px, nx, sat));
        my = 128'(dist_mag(q.py, body_py, ny, sat));
        if (mx == 0 && my == 0)
            zero = 1;
        else
        begin
            r2 = mx * mx + my * my;
            root = 0;
            for (int b = 63; b >= 0; b--)
            begin
                cand = root | (128'd1 << b);
                if (cand * cand <= r2)
                    root = cand;
            end
            num = (128'(grav_g) * 128'(q.mass)) << 24;
            quo = num / r2;
            gv = quo;
            if (quo > (128'd1 << (VW - 1)) - 1)
            begin
                sat = 1;
                gv = (128'd1 << (VW - 1)) - 1;
            end
            ax = 64'((gv * mx) / root);
            ay = 64'((gv * my) / root);
            if (nx) ax = -ax;
            if (ny) ay = -ay;
        end
        vx = sat_sum(64'(body_vx), ax, VW, sat);
        vy = sat_sum(64'(body_vy), ay, VW, sat);
        tx = sat_sum(64'(q.fx), vx, VW, sat);
        ty = sat_sum(64'(q.fy), vy, VW, sat);
        px = sat_sum(64'(body_px), tx >>> 8, PW, sat);
        py = sat_sum(64'(body_py), ty >>> 8, PW, sat);
        body_vx = vx[VW-1:0];
        body_vy = vy[VW-1:0];
        body_px = px[PW-1:0];
        body_py = py[PW-1:0];
        r.px = body_px;
        r.py = body_py;
        r.vx = body_vx;
        r.vy = body_vy;
        r.ax = ax[VW-1:0];
        r.ay = ay[VW-1:0];
        r.tx = tx[VW-1:0];
        r.ty = ty[VW-1:0];
        r.st = zero ? igs_pkg::ST_ZERO : (sat ? igs_pkg::ST_SAT : igs_pkg::ST_OK);
        return r;
    endfunction

    task automatic send_request(input request_t q, input bit typed, input result_t t);
        int gap;
        bit st;
        result_t p;
        gap = idle_off ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        parent_pos_x <= q.px;
        parent_pos_y <= q.py;
        parent_mass <= q.mass;
        frame_vel_x <= q.fx;
        frame_vel_y <= q.fy;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end
        while (st);
        p = gravity_step(q);
        expected_results.push_back(typed ? t : p);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [PW-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            igs_pkg::CFG_GRAV: grav_g = data[31:0];
            igs_pkg::CFG_POS_X: body_px = data;
            igs_pkg::CFG_POS_Y: body_py = data;
            igs_pkg::CFG_VEL_X: body_vx = data[VW-1:0];
            igs_pkg::CFG_VEL_Y: body_vy = data[VW-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        cfg_we <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [VW-1:0] vel_pick();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(VW-1){1'b1}}};
            1: return {1'b1, {(VW-1){1'b0}}};
            2: return VW'(rand64());
            default: return VW'(rand64() >> (64 - $urandom_range(1, 30)))
                            - (VW'(1) << 20);
        endcase
    endfunction

    function automatic logic signed [PW-1:0] pos_pick();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(PW-1){1'b1}}};
            1: return {1'b1, {(PW-1){1'b0}}};
            default: return PW'(rand64());
        endcase
    endfunction

    function automatic logic signed [PW-1:0] near(input logic signed [PW-1:0] b);
        logic signed [PW-1:0] off;
        off = PW'(rand64() >> (64 - $urandom_range(1, 40)));
        return $urandom_range(0, 1) ? b + off : b - off;
    endfunction

    function automatic request_t random_request();
        request_t q;
        q.mass = $urandom;
        if ($urandom_range(0, 99) < 15)
        begin
            q.px = PW'(rand64());
            q.py = PW'(rand64());
            q.fx = VW'(rand64());
            q.fy = VW'(rand64());
        end
        else
        begin
            q.px = $urandom_range(0, 30) == 0 ? body_px : near(body_px);
            q.py = $urandom_range(0, 30) == 0 ? body_py : near(body_py);
            q.fx = $urandom_range(0, 9) == 0 ? vel_pick() : VW'($signed($urandom) >>> 6);
            q.fy = $urandom_range(0, 9) == 0 ? vel_pick() : VW'($signed($urandom) >>> 6);
            if ($urandom_range(0, 3) == 0) q.mass = $urandom_range(0, 4096);
        end
        return q;
    endfunction

    // directed rows; the first three are known by inspection
    function automatic row_t mk(input logic signed [PW-1:0] px, input logic signed [PW-1:0] py,
                                input logic [31:0] m, input logic signed [VW-1:0] fx,
                                input logic signed [VW-1:0] fy);
        row_t w;
        w.req = '{px, py, m, fx, fy};
        w.typed = 0;
        w.res = '{default: '0};
        return w;
    endfunction

    localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    row_t table_a[$];
    row_t table_b[$];

    initial
    begin
        row_t w;
        table_a.push_back(mk(0, 0, 32'd256, 0, 0));
        table_a[0].typed = 1;
        table_a[0].res.st = igs_pkg::ST_ZERO;
        w = mk(48'sd65536, 0, 32'd256, 0, 0);
        w.typed = 1;
        w.res = '{48'sd65536, 0, 40'sd16777216, 0, 40'sd16777216, 0,
                  40'sd16777216, 0, igs_pkg::ST_OK};
        table_a.push_back(w);
        w = mk(48'sd65536, 0, 32'd256, 0, 0);
        w.typed = 1;
        w.res = '{48'sd131072, 0, 40'sd16777216, 0, 0, 0, 40'sd16777216, 0,
                  igs_pkg::ST_ZERO};
        table_a.push_back(w);
        table_a.push_back(mk(PMAX, PMIN, 32'hFFFF_FFFF, VMAX, VMIN));
        table_a.push_back(mk(PMIN, PMAX, 32'd0, VMIN, VMAX));
        table_a.push_back(mk(-48'sd1, 48'sd1, 32'hFFFF_FFFF, 0, 0));
        table_a.push_back(mk(48'sd12345, -48'sd99999, 32'h0001_0000, VMAX, VMAX));
        table_a.push_back(mk(-48'sd7000000, 48'sd3000000, 32'h8000_0000, -40'sd5000, 40'sd77));
        table_a.push_back(mk(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 32'h5555_5555,
                             40'h55_5555_5555, 40'hAA_AAAA_AAAA));
        table_a.push_back(mk(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'hAAAA_AAAA,
                             40'hAA_AAAA_AAAA, 40'h55_5555_5555));
        table_b.push_back(mk(PMIN, PMAX, 32'hFFFF_FFFF, 0, 0));
        table_b.push_back(mk(PMAX, PMIN, 32'hFFFF_FFFF, VMIN, VMAX));
        table_b.push_back(mk(0, 0, 32'd1, VMAX, VMIN));
        table_b.push_back(mk(48'sd1000, -48'sd1000, 32'hFFFF_FFFF, 0, 0));
    end

    // stimulus and phases
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (table_a[i]) send_request(table_a[i].req, table_a[i].typed, table_a[i].res);
        drain();
        cfg_write(igs_pkg::CFG_GRAV, 48'hFFFF_FFFF);
        cfg_write(igs_pkg::CFG_POS_X, PMAX);
        cfg_write(igs_pkg::CFG_POS_Y, PMIN);
        cfg_write(igs_pkg::CFG_VEL_X, 48'(VMAX));
        cfg_write(igs_pkg::CFG_VEL_Y, 48'(VMIN));
        cfg_write(CFG_UNUSED, 48'hFFFF_FFFF_FFFF);
        cfg_we <= 1'b0;
        foreach (table_b[i]) send_request(table_b[i].req, 0, table_b[i].res);
        drain();
        cfg_write(igs_pkg::CFG_GRAV, 48'd0);
        cfg_we <= 1'b0;
        foreach (table_b[i]) send_request(table_b[i].req, 0, table_b[i].res);
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain();
            case (ph % 4)
                0: cfg_write(igs_pkg::CFG_GRAV, 48'd16777216);
                1: cfg_write(igs_pkg::CFG_GRAV, 48'($urandom_range(0, 32'h0400_0000)));
                2: cfg_write(igs_pkg::CFG_GRAV, 48'($urandom));
                default: cfg_write(igs_pkg::CFG_GRAV, 48'hFFFF_FFFF);
            endcase
            cfg_write(igs_pkg::CFG_POS_X, pos_pick());
            cfg_write(igs_pkg::CFG_POS_Y, pos_pick());
            cfg_write(igs_pkg::CFG_VEL_X, 48'(vel_pick()));
            cfg_write(igs_pkg::CFG_VEL_Y, 48'(vel_pick()));
            cfg_we <= 1'b0;
            idle_off = (ph == 3);
            if (ph == 1) hold_long = 1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_request(random_request(), 0, table_a[0].res);
        end
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // result side
    initial
    begin
        int n;
        bit got;
        result_t a, e;
        forever
        begin
            n = idle_off ? 0 : $urandom_range(0, 16);
            if (hold_long)
            begin
                hold_long = 0;
                n = 3000;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got = out_valid;
                a = '{new_pos_x, new_pos_y, new_vel_x, new_vel_y, accel_x, accel_y,
                      total_vel_x, total_vel_y, status};
                @(posedge clk);
            end
            while (!got);
            if (expected_results.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (a.px !== e.px) begin $error("new_pos_x exp %0d got %0d", e.px, a.px); errors++; end
                if (a.py !== e.py) begin $error("new_pos_y exp %0d got %0d", e.py, a.py); errors++; end
                if (a.vx !== e.vx) begin $error("new_vel_x exp %0d got %0d", e.vx, a.vx); errors++; end
                if (a.vy !== e.vy) begin $error("new_vel_y exp %0d got %0d", e.vy, a.vy); errors++; end
                if (a.ax !== e.ax) begin $error("accel_x exp %0d got %0d", e.ax, a.ax); errors++; end
                if (a.ay !== e.ay) begin $error("accel_y exp %0d got %0d", e.ay, a.ay); errors++; end
                if (a.tx !== e.tx) begin $error("total_vel_x exp %0d got %0d", e.tx, a.tx); errors++; end
                if (a.ty !== e.ty) begin $error("total_vel_y exp %0d got %0d", e.ty, a.ty); errors++; end
                if (a.st !== e.st) begin $error("status exp %0d got %0d", e.st, a.st); errors++; end
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/igs_pkg.sv
hw/rtl/igs_addsub.sv
hw/rtl/igs_core.sv
hw/rtl/inverse_square_gravity_step.sv
verif/testbench.sv
